// ----- rtl/power_of_two_bucket_allocator_assert.svh -----
// assertion macros shared by the allocator checker
// depends on nothing; included by the checker file
`ifndef POWER_OF_TWO_BUCKET_ALLOCATOR_ASSERT_SVH
`define POWER_OF_TWO_BUCKET_ALLOCATOR_ASSERT_SVH

// implication checked on every clock edge outside reset
`define PBA_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define PBA_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- rtl/pba_pkg.sv -----
// shared constants and types of the power-of-two bucket allocator
// no dependencies
package pba_pkg;

  localparam int ARENA_BYTES_DEF     = 1048576;
  localparam int CLUSTER_BYTES_DEF   = 4096;
  localparam int PAGE_BYTES_DEF      = 4096;
  localparam int MIN_BUCKET_LOG2_DEF = 4;
  localparam int MAX_SAVED_BYTES_DEF = 8192;

  localparam int OFS_W    = 21;
  localparam int ADDR_W   = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOMEM     = 2'd1,
    ST_IGNORED   = 2'd2,
    ST_LARGE_UNS = 2'd3
  } status_t;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] REG_ARENA_BASE   = 2'd0;
  localparam logic [1:0] REG_START_OFFSET = 2'd1;

endpackage

// ----- rtl/pba_ram.sv -----
// generic single-port-write, single-read synchronous ram
// registered read data; no dependencies
module pba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/power_of_two_bucket_allocator.sv -----
// Power-of-two bucket allocator.
// Channels: in_ request stream (tuser = req_type, tdata = request_size then
// free_address), out_ result stream (tdata = granted_address then status),
// cfg_ APB port with arena_base at 0x0 and start_offset at 0x4.
// Small allocates map to bucket max(MIN_BUCKET_LOG2, ceil(log2(size))) and
// take the head of that bucket's free list; an empty list is refilled by
// carving cluster-rounded space from the bump pointer and linking its pieces one piece
// per cycle. Large allocates take whole clusters. Frees append to the tail.
// Flow: one request at a time. An allocate from a non-empty bucket reads
// the next link through the slot ram (usage-free path, registered read),
// a free reads the usage ram (skipped when outside the arena), and a large
// allocate or an out-of-memory answer goes straight to the result. A refill
// links its carved pieces through the piece-link ram write port, up to
// CLUSTER/2^MIN pieces.
// Reset: bump pointer loads 4096, arena_base 0, all buckets empty; no
// clearing pass is needed. The result sits in an output register; while
// out_tready is low the block holds it and accepts no new request.
module power_of_two_bucket_allocator
  import pba_pkg::*;
#(
  parameter int ARENA_BYTES     = ARENA_BYTES_DEF,
  parameter int CLUSTER_BYTES   = CLUSTER_BYTES_DEF,
  parameter int PAGE_BYTES      = PAGE_BYTES_DEF,
  parameter int MIN_BUCKET_LOG2 = MIN_BUCKET_LOG2_DEF,
  parameter int MAX_SAVED_BYTES = MAX_SAVED_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [20:0] request_size, [52:21] free_address, [55:53] zero
  input  logic [55:0] in_tdata,
  // [0] req_type
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] granted_address, [33:32] status, [39:34] zero
  output logic [39:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int NUM_BUCKETS  = MIN_BUCKET_LOG2 + 17;
  localparam int LARGE_INDEX  = NUM_BUCKETS - 1;
  localparam int BKT_W        = $clog2(NUM_BUCKETS);
  localparam int NUM_CLUSTERS = (ARENA_BYTES + CLUSTER_BYTES - 1) / CLUSTER_BYTES;
  localparam int CL_W         = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;
  localparam int NUM_SLOTS    = ARENA_BYTES >> MIN_BUCKET_LOG2;
  localparam int SLOT_W       = $clog2(NUM_SLOTS);
  localparam int ARENA_W      = $clog2(ARENA_BYTES) + 1;
  localparam int CLOG2        = $clog2(CLUSTER_BYTES);
  localparam int PLOG2        = $clog2(PAGE_BYTES);
  localparam int SAVED_LOG2   = $clog2(MAX_SAVED_BYTES);
  localparam int W            = ARENA_W + 2;
  localparam logic [W-1:0] ARENA_LIM = W'(ARENA_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_CARVE, S_HEAD_RD, S_HEAD_WAIT, S_FREE_RD, S_FREE_WAIT,
    S_OUT
  } state_t;

  state_t state_r;
  logic [31:0] arena_base_r;
  logic [OFS_W-1:0] start_offset_r;
  logic [W-1:0] bump_r;
  logic req_type_r;
  logic [OFS_W-1:0] size_r;
  logic [31:0] faddr_r;
  logic [BKT_W-1:0] bkt_r;
  logic [NUM_BUCKETS-1:0] bvalid_r;
  logic [W-1:0] bhead_r [NUM_BUCKETS];
  logic [W-1:0] btail_r [NUM_BUCKETS];
  logic [W-1:0] carve_r, cend_r, grant_r;
  logic [1:0] status_r;
  logic [W-1:0] foff_r;
  logic out_valid_r;
  logic [31:0] out_addr_r;
  logic [1:0] out_status_r;

  // memories
  logic slot_we;
  logic [SLOT_W-1:0] slot_waddr, slot_raddr;
  logic [W-1:0] slot_wdata, slot_rdata;
  logic use_we;
  logic [CL_W-1:0] use_waddr, use_raddr;
  logic [BKT_W-1:0] use_wdata, use_rdata;

  pba_ram #(.WIDTH(W), .DEPTH(NUM_SLOTS)) u_next (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rdata)
  );
  pba_ram #(.WIDTH(BKT_W), .DEPTH(1 << CL_W)) u_usage (
    .clk(clk), .we(use_we), .waddr(use_waddr), .wdata(use_wdata),
    .raddr(use_raddr), .rdata(use_rdata)
  );

  // config write and read
  logic cfg_wr;
  logic [W-1:0] start_rnd;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  always_comb begin
    start_rnd = ((W'(cfg_pwdata[OFS_W-1:0]) + W'(PAGE_BYTES - 1)) >> PLOG2) << PLOG2;
    if (start_rnd > ARENA_LIM) start_rnd = ARENA_LIM;
    case (cfg_paddr[2 +: 1])
      REG_ARENA_BASE[0]: cfg_prdata = arena_base_r;
      default:           cfg_prdata = 32'(start_offset_r);
    endcase
  end

  // bucket index of the captured size
  logic [BKT_W-1:0] bkt_calc;
  always_comb begin
    bkt_calc = BKT_W'(MIN_BUCKET_LOG2);
    for (int b = SAVED_LOG2; b >= MIN_BUCKET_LOG2 + 1; b--) begin
      if (size_r > OFS_W'(1 << (b - 1))) begin
        if (bkt_calc == BKT_W'(MIN_BUCKET_LOG2)) bkt_calc = BKT_W'(b);
      end
    end
  end

  // carve span and piece count for the captured request
  logic [W-1:0] piece, span_c, span_p, bump_end, ncut;
  logic fits, is_small;
  assign is_small = (W'(size_r) <= W'(MAX_SAVED_BYTES));
  always_comb begin
    piece = W'(1) << bkt_calc;
    if (is_small) span_c = ((piece + W'(CLUSTER_BYTES - 1)) >> CLOG2) << CLOG2;
    else          span_c = ((W'(size_r) + W'(CLUSTER_BYTES - 1)) >> CLOG2) << CLOG2;
    span_p   = ((span_c + W'(PAGE_BYTES - 1)) >> PLOG2) << PLOG2;
    bump_end = bump_r + span_p;
    fits     = (span_p <= ARENA_LIM) && (bump_end <= ARENA_LIM);
    ncut     = span_c >> bkt_calc;
    if (ncut == '0) ncut = W'(1);
  end

  logic [W-1:0] pstep;
  assign pstep = W'(1) << bkt_r;
  logic [W-1:0] foff_c;
  assign foff_c = W'(faddr_r - arena_base_r);
  logic out_of_arena;
  assign out_of_arena = (faddr_r - arena_base_r) >= 32'(ARENA_BYTES);

  function automatic logic [CL_W-1:0] cl_of(input logic [W-1:0] o);
    return CL_W'((o >> CLOG2) % NUM_CLUSTERS);
  endfunction

  assign in_tready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_status_r, out_addr_r};

  // memory port control
  always_comb begin
    slot_we = 1'b0; slot_waddr = SLOT_W'(carve_r >> MIN_BUCKET_LOG2);
    slot_wdata = carve_r + pstep;
    slot_raddr = SLOT_W'(bhead_r[bkt_r] >> MIN_BUCKET_LOG2);
    use_we = 1'b0; use_waddr = cl_of(bump_r); use_wdata = bkt_calc;
    use_raddr = cl_of(foff_c);
    case (state_r)
      S_DECODE: begin
        if (req_type_r == REQ_ALLOC && fits && (!is_small || !bvalid_r[bkt_calc])) begin
          use_we = 1'b1;
          use_wdata = is_small ? bkt_calc : BKT_W'(LARGE_INDEX);
        end
      end
      S_CARVE: slot_we = (carve_r + pstep < cend_r);
      S_FREE_WAIT: begin
        if (use_rdata == BKT_W'(LARGE_INDEX)) begin
          use_we = 1'b1; use_waddr = cl_of(foff_r); use_wdata = '0;
        end else if (use_rdata >= BKT_W'(MIN_BUCKET_LOG2) &&
                     use_rdata < BKT_W'(NUM_BUCKETS) && bvalid_r[use_rdata]) begin
          slot_we = 1'b1;
          slot_waddr = SLOT_W'(btail_r[use_rdata] >> MIN_BUCKET_LOG2);
          slot_wdata = (foff_r >> MIN_BUCKET_LOG2) << MIN_BUCKET_LOG2;
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; out_valid_r <= 1'b0; bvalid_r <= '0;
      arena_base_r <= '0; start_offset_r <= OFS_W'(4096);
      bump_r <= W'(4096);
    end else begin
      if (cfg_wr && cfg_paddr[2 +: 1] == REG_ARENA_BASE[0]) arena_base_r <= cfg_pwdata;
      if (cfg_wr && cfg_paddr[2 +: 1] == REG_START_OFFSET[0]) begin
        start_offset_r <= cfg_pwdata[OFS_W-1:0];
        bump_r <= start_rnd;
      end
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            req_type_r <= in_tuser; size_r <= in_tdata[20:0];
            faddr_r <= in_tdata[52:21]; state_r <= S_DECODE;
          end
        end
        S_DECODE: begin
          bkt_r <= bkt_calc;
          if (req_type_r == REQ_FREE) begin
            foff_r <= foff_c;
            if (out_of_arena) begin
              grant_r <= '0; status_r <= ST_IGNORED; state_r <= S_OUT;
            end else state_r <= S_FREE_WAIT;
          end else if (is_small && bvalid_r[bkt_calc]) begin
            state_r <= S_HEAD_RD;
          end else if (!fits) begin
            grant_r <= '0; status_r <= ST_NOMEM; state_r <= S_OUT;
          end else if (!is_small) begin
            grant_r <= bump_r; status_r <= ST_OK; bump_r <= bump_end;
            state_r <= S_OUT;
          end else begin
            carve_r <= bump_r;
            cend_r  <= bump_r + (ncut << bkt_calc);
            bhead_r[bkt_calc] <= bump_r;
            btail_r[bkt_calc] <= bump_r + ((ncut - W'(1)) << bkt_calc);
            bvalid_r[bkt_calc] <= 1'b1;
            bump_r <= bump_end;
            state_r <= S_CARVE;
          end
        end
        S_CARVE: begin
          carve_r <= carve_r + pstep;
          if (carve_r + pstep >= cend_r) state_r <= S_HEAD_RD;
        end
        S_HEAD_RD: state_r <= S_HEAD_WAIT;
        S_HEAD_WAIT: begin
          grant_r <= bhead_r[bkt_r]; status_r <= ST_OK;
          if (bhead_r[bkt_r] == btail_r[bkt_r]) bvalid_r[bkt_r] <= 1'b0;
          else bhead_r[bkt_r] <= slot_rdata;
          state_r <= S_OUT;
        end
        S_FREE_WAIT: begin
          grant_r <= '0;
          if (use_rdata == BKT_W'(LARGE_INDEX)) status_r <= ST_LARGE_UNS;
          else if (use_rdata < BKT_W'(MIN_BUCKET_LOG2) ||
                   use_rdata >= BKT_W'(NUM_BUCKETS)) status_r <= ST_IGNORED;
          else begin
            status_r <= ST_OK;
            if (!bvalid_r[use_rdata])
              bhead_r[use_rdata] <= (foff_r >> MIN_BUCKET_LOG2) << MIN_BUCKET_LOG2;
            bvalid_r[use_rdata] <= 1'b1;
            btail_r[use_rdata] <= (foff_r >> MIN_BUCKET_LOG2) << MIN_BUCKET_LOG2;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          out_addr_r <= (status_r == ST_OK && req_type_r == REQ_ALLOC) ?
                        arena_base_r + 32'(grant_r) : 32'd0;
          out_status_r <= status_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/pba_checker.sv -----
// port-level checker for the allocator, bound to the top level
// depends on pba_pkg and the assertion macro header
`include "power_of_two_bucket_allocator_assert.svh"
module pba_checker
  import pba_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  `PBA_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata), "result changed while stalled")
  `PBA_ASSERT_IMP(a_free_zero, clk, rst_n, out_tvalid && out_tdata[33:32] != ST_OK, out_tdata[31:0] == 32'd0, "nonzero address without grant")
  `PBA_ASSERT_IMP(a_no_take, clk, rst_n, out_tvalid, !in_tready, "request taken while result pending")
  `PBA_ASSERT_NXT(a_accept_busy, clk, rst_n, in_tvalid && in_tready, !in_tready, "back to back accept")

endmodule

bind power_of_two_bucket_allocator pba_checker u_pba_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata)
);
